// File: design/rrt_pkg.sv
// Package for the reserved range table: command and status codes, the
// table entry layout, controller states and the controller/datapath link.
// No dependencies.
package rrt_pkg;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_FIND   = 2'd2;
    localparam logic [1:0] CMD_PURGE  = 2'd3;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_INVALID = 3'd1,
        ST_FULL    = 3'd2,
        ST_OVERLAP = 3'd3,
        ST_NONE    = 3'd4
    } t_status;

    typedef struct packed {
        logic [63:0] range_start;
        logic [63:0] range_end;
        logic        tmp;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN_RD,
        S_SCAN_EV,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_INIT,
        DP_READ_IDX,
        DP_IDX_INC,
        DP_MARK,
        DP_PURGE_STEP,
        DP_FIND_STEP,
        DP_SHIFT_SETUP,
        DP_SHIFT_READ,
        DP_SHIFT_WRITE,
        DP_PUT,
        DP_DEL,
        DP_PURGE_END,
        DP_RESULT
    } t_dp_op;

    typedef struct packed {
        t_dp_op  op;
        t_status status;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] cmd;
        logic       s_ge_e;
        logic       s_gt_e;
        logic       full;
        logic       find_none0;
        logic       idx_end;
        logic       ov;
        logic       contained;
        logic       ends_below;
        logic       match;
        logic       find_none;
        logic       shift_end;
        logic       out_busy;
    } t_dp_flags;

endpackage

// File: design/rrt_in_if.sv
// Request channel of the reserved range table: valid, ready and one
// command beat. Depends on nothing.
interface rrt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [63:0] range_start;
    logic [63:0] range_end;
    logic        temporary;

    modport source (output valid, cmd, range_start, range_end, temporary, input ready);
    modport sink (input valid, cmd, range_start, range_end, temporary, output ready);
endinterface

// File: design/rrt_out_if.sv
// Response channel of the reserved range table: valid, ready and one
// result beat. The entry count width is set by the parameter CW.
interface rrt_out_if #(
    parameter int CW = 7
);
    logic          valid;
    logic          ready;
    logic [2:0]    status;
    logic [63:0]   gap_start;
    logic [63:0]   gap_end;
    logic [CW-1:0] entry_count;

    modport source (output valid, status, gap_start, gap_end, entry_count, input ready);
    modport sink (input valid, status, gap_start, gap_end, entry_count, output ready);
endinterface

// File: design/rrt_ctrl.sv
// Controller of the reserved range table: sequences scan, shift and result
// steps for each command. Depends on rrt_pkg.
module rrt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  rrt_pkg::t_dp_flags i_flags,
    output logic               o_in_ready,
    output rrt_pkg::t_dp_cmd   o_cmd
);

    rrt_pkg::t_state  r_state, n_state;
    rrt_pkg::t_status r_status, n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rrt_pkg::S_IDLE;
            r_status <= rrt_pkg::ST_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_status     = r_status;
        o_in_ready   = 1'b0;
        o_cmd.op     = rrt_pkg::DP_NOP;
        o_cmd.status = r_status;
        unique case (r_state)
            rrt_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = rrt_pkg::DP_LOAD;
                    n_state  = rrt_pkg::S_CHECK;
                end
            end
            rrt_pkg::S_CHECK: begin
                n_state  = rrt_pkg::S_DONE;
                o_cmd.op = rrt_pkg::DP_INIT;
                unique case (i_flags.cmd)
                    rrt_pkg::CMD_INSERT: begin
                        if (i_flags.s_ge_e) begin
                            n_status = rrt_pkg::ST_INVALID;
                        end else if (i_flags.full) begin
                            n_status = rrt_pkg::ST_FULL;
                        end else begin
                            n_state = rrt_pkg::S_SCAN_RD;
                        end
                    end
                    rrt_pkg::CMD_REMOVE: begin
                        if (i_flags.s_ge_e) begin
                            n_status = rrt_pkg::ST_INVALID;
                        end else begin
                            n_state = rrt_pkg::S_SCAN_RD;
                        end
                    end
                    rrt_pkg::CMD_FIND: begin
                        if (i_flags.s_gt_e) begin
                            n_status = rrt_pkg::ST_INVALID;
                        end else if (i_flags.find_none0) begin
                            n_status = rrt_pkg::ST_NONE;
                        end else begin
                            n_state = rrt_pkg::S_SCAN_RD;
                        end
                    end
                    default: begin
                        n_state = rrt_pkg::S_SCAN_RD;
                    end
                endcase
            end
            rrt_pkg::S_SCAN_RD: begin
                if (i_flags.idx_end) begin
                    n_state  = rrt_pkg::S_DONE;
                    n_status = rrt_pkg::ST_OK;
                    unique case (i_flags.cmd)
                        rrt_pkg::CMD_INSERT: begin
                            o_cmd.op = rrt_pkg::DP_SHIFT_SETUP;
                            n_state  = rrt_pkg::S_SHIFT_RD;
                        end
                        rrt_pkg::CMD_REMOVE: n_status = rrt_pkg::ST_NONE;
                        rrt_pkg::CMD_FIND:   n_status = rrt_pkg::ST_OK;
                        default:             o_cmd.op = rrt_pkg::DP_PURGE_END;
                    endcase
                end else begin
                    o_cmd.op = rrt_pkg::DP_READ_IDX;
                    n_state  = rrt_pkg::S_SCAN_EV;
                end
            end
            rrt_pkg::S_SCAN_EV: begin
                n_state = rrt_pkg::S_SCAN_RD;
                unique case (i_flags.cmd)
                    rrt_pkg::CMD_INSERT: begin
                        if (i_flags.ov) begin
                            n_state = rrt_pkg::S_DONE;
                            if (i_flags.contained) begin
                                o_cmd.op = rrt_pkg::DP_MARK;
                                n_status = rrt_pkg::ST_OK;
                            end else begin
                                n_status = rrt_pkg::ST_OVERLAP;
                            end
                        end else if (i_flags.ends_below) begin
                            o_cmd.op = rrt_pkg::DP_SHIFT_SETUP;
                            n_state  = rrt_pkg::S_SHIFT_RD;
                        end else begin
                            o_cmd.op = rrt_pkg::DP_IDX_INC;
                        end
                    end
                    rrt_pkg::CMD_REMOVE: begin
                        if (i_flags.match) begin
                            o_cmd.op = rrt_pkg::DP_SHIFT_SETUP;
                            n_state  = rrt_pkg::S_SHIFT_RD;
                        end else begin
                            o_cmd.op = rrt_pkg::DP_IDX_INC;
                        end
                    end
                    rrt_pkg::CMD_FIND: begin
                        if (i_flags.find_none) begin
                            n_status = rrt_pkg::ST_NONE;
                            n_state  = rrt_pkg::S_DONE;
                        end else begin
                            o_cmd.op = rrt_pkg::DP_FIND_STEP;
                        end
                    end
                    default: o_cmd.op = rrt_pkg::DP_PURGE_STEP;
                endcase
            end
            rrt_pkg::S_SHIFT_RD: begin
                if (i_flags.shift_end) begin
                    n_status = rrt_pkg::ST_OK;
                    n_state  = rrt_pkg::S_DONE;
                    o_cmd.op = (i_flags.cmd == rrt_pkg::CMD_INSERT) ?
                               rrt_pkg::DP_PUT : rrt_pkg::DP_DEL;
                end else begin
                    o_cmd.op = rrt_pkg::DP_SHIFT_READ;
                    n_state  = rrt_pkg::S_SHIFT_WR;
                end
            end
            rrt_pkg::S_SHIFT_WR: begin
                o_cmd.op = rrt_pkg::DP_SHIFT_WRITE;
                n_state  = rrt_pkg::S_SHIFT_RD;
            end
            rrt_pkg::S_DONE: begin
                // The result waits here while the previous beat is still held.
                if (!i_flags.out_busy) begin
                    o_cmd.op = rrt_pkg::DP_RESULT;
                    n_state  = rrt_pkg::S_IDLE;
                end
            end
            default: n_state = rrt_pkg::S_IDLE;
        endcase
    end

endmodule

// File: design/rrt_dp.sv
// Datapath of the reserved range table: the entry memory, scan pointers,
// gap registers and the result register. Depends on rrt_pkg.
module rrt_dp #(
    parameter int TABLE_DEPTH = 64,
    parameter int PAGE_BITS   = 12,
    parameter int CW          = $clog2(TABLE_DEPTH + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rrt_pkg::t_dp_cmd   i_cmd,
    input  logic [1:0]         i_op,
    input  logic [63:0]        i_range_start,
    input  logic [63:0]        i_range_end,
    input  logic               i_temporary,
    input  logic               i_out_ready,
    output rrt_pkg::t_dp_flags o_flags,
    output logic               o_out_valid,
    output logic [2:0]         o_status,
    output logic [63:0]        o_gap_start,
    output logic [63:0]        o_gap_end,
    output logic [CW-1:0]      o_entry_count
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [63:0] PageMask = (64'd1 << PAGE_BITS) - 64'd1;

    rrt_pkg::t_entry r_mem [TABLE_DEPTH];
    rrt_pkg::t_entry r_rd;

    logic [1:0]    r_op;
    logic [63:0]   r_s, r_e, r_gs, r_ge;
    logic          r_tmp;
    logic [CW-1:0] r_count, r_idx, r_w, r_k;
    logic          r_out_valid;
    logic [2:0]    r_status;
    logic [63:0]   r_gap_start, r_gap_end;
    logic [CW-1:0] r_entry_count;

    logic [63:0]     gs0, ge0, ds, de;
    logic            top, skip;
    logic [CW-1:0]   rd_ptr, wr_ptr;
    logic            wr_en;
    rrt_pkg::t_entry wr_data;
    logic            is_insert;

    assign is_insert = (r_op == rrt_pkg::CMD_INSERT);
    assign gs0 = (r_s + PageMask) & ~PageMask;
    assign ge0 = r_e & ~PageMask;
    assign ds  = r_rd.range_start & ~PageMask;
    assign de  = (r_rd.range_end + PageMask) & ~PageMask;
    // A widened end that wraps reaches the top of the address space.
    assign top  = de < r_rd.range_end;
    assign skip = (!top && de <= r_gs) || ds >= r_ge;

    always_comb begin
        o_flags.cmd        = r_op;
        o_flags.s_ge_e     = r_s >= r_e;
        o_flags.s_gt_e     = r_s > r_e;
        o_flags.full       = r_count == CW'(TABLE_DEPTH);
        o_flags.find_none0 = (gs0 < r_s) || (gs0 >= ge0);
        o_flags.idx_end    = r_idx == r_count;
        o_flags.ov         = (r_e > r_rd.range_start) && (r_s < r_rd.range_end);
        o_flags.contained  = (r_s >= r_rd.range_start) && (r_e <= r_rd.range_end);
        o_flags.ends_below = r_e <= r_rd.range_start;
        o_flags.match      = (r_rd.range_start == r_s) && (r_rd.range_end == r_e);
        o_flags.find_none  = !skip && !(ds > r_gs) && (top || de >= r_ge);
        o_flags.shift_end  = is_insert ? (r_k == r_idx) :
                             ({1'b0, r_k} + {{CW{1'b0}}, 1'b1} >= {1'b0, r_count});
        o_flags.out_busy   = r_out_valid && !i_out_ready;
    end

    always_comb begin
        rd_ptr  = r_idx;
        wr_ptr  = r_idx;
        wr_en   = 1'b0;
        wr_data = r_rd;
        if (i_cmd.op == rrt_pkg::DP_SHIFT_READ) begin
            rd_ptr = is_insert ? (r_k - CW'(1)) : (r_k + CW'(1));
        end
        case (i_cmd.op)
            rrt_pkg::DP_MARK: begin
                wr_en       = 1'b1;
                wr_data.tmp = r_rd.tmp & r_tmp;
            end
            rrt_pkg::DP_PURGE_STEP: begin
                wr_en       = !r_rd.tmp;
                wr_ptr      = r_w;
                wr_data.tmp = 1'b0;
            end
            rrt_pkg::DP_SHIFT_WRITE: begin
                wr_en  = 1'b1;
                wr_ptr = r_k;
            end
            rrt_pkg::DP_PUT: begin
                wr_en               = 1'b1;
                wr_data.range_start = r_s;
                wr_data.range_end   = r_e;
                wr_data.tmp         = r_tmp;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[rd_ptr[AW-1:0]];
        if (wr_en) begin
            r_mem[wr_ptr[AW-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            rrt_pkg::DP_LOAD: begin
                r_op  <= i_op;
                r_s   <= i_range_start;
                r_e   <= i_range_end;
                r_tmp <= i_temporary;
            end
            rrt_pkg::DP_INIT: begin
                r_idx <= '0;
                r_w   <= '0;
                r_gs  <= gs0;
                r_ge  <= ge0;
            end
            rrt_pkg::DP_IDX_INC: r_idx <= r_idx + CW'(1);
            rrt_pkg::DP_PURGE_STEP: begin
                r_idx <= r_idx + CW'(1);
                if (!r_rd.tmp) begin
                    r_w <= r_w + CW'(1);
                end
            end
            rrt_pkg::DP_FIND_STEP: begin
                r_idx <= r_idx + CW'(1);
                if (!skip) begin
                    if (ds > r_gs) begin
                        r_ge <= ds;
                    end else begin
                        r_gs <= de;
                    end
                end
            end
            rrt_pkg::DP_SHIFT_SETUP: r_k <= is_insert ? r_count : r_idx;
            rrt_pkg::DP_SHIFT_WRITE: r_k <= is_insert ? (r_k - CW'(1)) : (r_k + CW'(1));
            rrt_pkg::DP_RESULT: begin
                r_status      <= i_cmd.status;
                r_entry_count <= r_count;
                if (r_op == rrt_pkg::CMD_FIND && i_cmd.status == rrt_pkg::ST_OK) begin
                    r_gap_start <= r_gs;
                    r_gap_end   <= r_ge;
                end else begin
                    r_gap_start <= '0;
                    r_gap_end   <= '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (i_cmd.op)
                rrt_pkg::DP_PUT:       r_count <= r_count + CW'(1);
                rrt_pkg::DP_DEL:       r_count <= r_count - CW'(1);
                rrt_pkg::DP_PURGE_END: r_count <= r_w;
                default: ;
            endcase
            if (i_cmd.op == rrt_pkg::DP_RESULT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_gap_start   = r_gap_start;
    assign o_gap_end     = r_gap_end;
    assign o_entry_count = r_entry_count;

endmodule

// File: design/reserved_range_table_unit.sv
// Top level of the reserved range table: controller plus datapath.
// Depends on rrt_pkg, rrt_in_if, rrt_out_if, rrt_ctrl and rrt_dp.
//
// Usage: i_req carries one command beat (insert, remove exact, find free
// gap, purge temporary) and o_rsp returns exactly one result beat for it.
// One command is handled at a time; i_req.ready is high only while the
// controller is idle.
// The table is read one entry at a time through the entry memory, which
// has one read and one write port, and an insert or remove then moves
// each later entry with a read step and a write step. Rejected commands
// go from the check straight to the result.
// Reset empties the table at once by clearing the entry count; no sweep of
// the memory is needed. When the receiver stalls, the result beat holds on
// o_rsp while the next command is still taken and processed; its result
// waits in the controller until the held beat has been delivered.
module reserved_range_table_unit #(
    parameter int TABLE_DEPTH = 64,
    parameter int PAGE_BITS   = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rrt_in_if.sink      i_req,
    rrt_out_if.source   o_rsp
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    rrt_pkg::t_dp_cmd   dp_cmd;
    rrt_pkg::t_dp_flags dp_flags;
    logic [CW-1:0]      entry_count;

    rrt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_flags    (dp_flags),
        .o_in_ready (i_req.ready),
        .o_cmd      (dp_cmd)
    );

    rrt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .PAGE_BITS   (PAGE_BITS),
        .CW          (CW)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .i_op          (i_req.cmd),
        .i_range_start (i_req.range_start),
        .i_range_end   (i_req.range_end),
        .i_temporary   (i_req.temporary),
        .i_out_ready   (o_rsp.ready),
        .o_flags       (dp_flags),
        .o_out_valid   (o_rsp.valid),
        .o_status      (o_rsp.status),
        .o_gap_start   (o_rsp.gap_start),
        .o_gap_end     (o_rsp.gap_end),
        .o_entry_count (entry_count)
    );

    assign o_rsp.entry_count = entry_count;

endmodule

// File: tb/sv/tb_rrt_checker.sv
// Scoreboard for the reserved range table: watches both channels, keeps its
// own model of the table and compares every result beat. Depends on rrt_pkg.
module tb_rrt_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [1:0]  i_cmd,
    input  logic [63:0] i_range_start,
    input  logic [63:0] i_range_end,
    input  logic        i_temporary,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  logic [2:0]  i_status,
    input  logic [63:0] i_gap_start,
    input  logic [63:0] i_gap_end,
    input  logic [6:0]  i_entry_count,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 64;
    localparam logic [63:0] PMASK = 64'hFFF;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] gap_start;
        logic [63:0] gap_end;
        logic [6:0]  entry_count;
    } t_result;

    logic [63:0] tbl_start [DEPTH];
    logic [63:0] tbl_end [DEPTH];
    logic        tbl_tmp [DEPTH];
    int          n_entries;
    t_result     expected_q[$];

    function automatic void drop_entry(int pos);
        for (int k = pos; k + 1 < n_entries; k++) begin
            tbl_start[k] = tbl_start[k+1];
            tbl_end[k]   = tbl_end[k+1];
            tbl_tmp[k]   = tbl_tmp[k+1];
        end
        n_entries--;
    endfunction

    function automatic rrt_pkg::t_status table_insert(logic [63:0] s, logic [63:0] e,
                                                      logic t);
        int i;
        if (s >= e) return rrt_pkg::ST_INVALID;
        if (n_entries >= DEPTH) return rrt_pkg::ST_FULL;
        for (i = 0; i < n_entries; i++) begin
            if (e > tbl_start[i] && s < tbl_end[i]) begin
                if (s >= tbl_start[i] && e <= tbl_end[i]) begin
                    if (tbl_tmp[i] != t) tbl_tmp[i] = 1'b0;
                    return rrt_pkg::ST_OK;
                end
                return rrt_pkg::ST_OVERLAP;
            end
            if (e <= tbl_start[i]) break;
        end
        for (int k = n_entries; k > i; k--) begin
            tbl_start[k] = tbl_start[k-1];
            tbl_end[k]   = tbl_end[k-1];
            tbl_tmp[k]   = tbl_tmp[k-1];
        end
        tbl_start[i] = s;
        tbl_end[i]   = e;
        tbl_tmp[i]   = t;
        n_entries++;
        return rrt_pkg::ST_OK;
    endfunction

    function automatic rrt_pkg::t_status table_remove(logic [63:0] s, logic [63:0] e);
        if (s >= e) return rrt_pkg::ST_INVALID;
        for (int i = 0; i < n_entries; i++) begin
            if (tbl_start[i] == s && tbl_end[i] == e) begin
                drop_entry(i);
                return rrt_pkg::ST_OK;
            end
        end
        return rrt_pkg::ST_NONE;
    endfunction

    function automatic rrt_pkg::t_status find_gap(logic [63:0] s, logic [63:0] e,
                                                  output logic [63:0] gs,
                                                  output logic [63:0] ge);
        logic [63:0] ds, de;
        logic        top;
        gs = 64'd0;
        ge = 64'd0;
        if (s > e) return rrt_pkg::ST_INVALID;
        gs = (s + PMASK) & ~PMASK;
        ge = e & ~PMASK;
        if (gs < s || gs >= ge) return rrt_pkg::ST_NONE;
        for (int i = 0; i < n_entries; i++) begin
            ds  = tbl_start[i] & ~PMASK;
            de  = (tbl_end[i] + PMASK) & ~PMASK;
            top = de < tbl_end[i];
            if (!((!top && de <= gs) || ds >= ge)) begin
                if (ds > gs) begin
                    ge = ds;
                end else begin
                    if (top || de >= ge) return rrt_pkg::ST_NONE;
                    gs = de;
                end
            end
        end
        return rrt_pkg::ST_OK;
    endfunction

    function automatic void purge_temporary();
        int w;
        w = 0;
        for (int r = 0; r < n_entries; r++) begin
            if (!tbl_tmp[r]) begin
                tbl_start[w] = tbl_start[r];
                tbl_end[w]   = tbl_end[r];
                tbl_tmp[w]   = 1'b0;
                w++;
            end
        end
        n_entries = w;
    endfunction

    function automatic t_result table_step(logic [1:0] c, logic [63:0] s, logic [63:0] e,
                                           logic t);
        t_result r;
        logic [63:0] gs, ge;
        r = '0;
        case (c)
            rrt_pkg::CMD_INSERT: r.status = table_insert(s, e, t);
            rrt_pkg::CMD_REMOVE: r.status = table_remove(s, e);
            rrt_pkg::CMD_FIND: begin
                r.status = find_gap(s, e, gs, ge);
                if (r.status == rrt_pkg::ST_OK) begin
                    r.gap_start = gs;
                    r.gap_end   = ge;
                end
            end
            default: begin
                purge_temporary();
                r.status = rrt_pkg::ST_OK;
            end
        endcase
        r.entry_count = 7'(n_entries);
        return r;
    endfunction

    initial begin
        o_errors  = 0;
        n_entries = 0;
    end

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (i_req_valid && i_req_ready)
                expected_q.push_back(table_step(i_cmd, i_range_start, i_range_end,
                                                i_temporary));
            if (i_rsp_valid && i_rsp_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%t: unexpected result beat status=%0d", $time, i_status);
                    o_errors++;
                end else begin
                    want = expected_q.pop_front();
                    if (i_status !== want.status || i_gap_start !== want.gap_start ||
                        i_gap_end !== want.gap_end ||
                        i_entry_count !== want.entry_count) begin
                        $display({"%t: expected st=%0d gs=%h ge=%h n=%0d,",
                                  " got st=%0d gs=%h ge=%h n=%0d"},
                                 $time, want.status, want.gap_start, want.gap_end,
                                 want.entry_count, i_status, i_gap_start, i_gap_end,
                                 i_entry_count);
                        o_errors++;
                    end
                end
            end
        end
    end
endmodule

// File: tb/sv/tb_reserved_range_table_unit.sv
// Testbench top for reserved_range_table_unit: drives command beats, stalls
// the result channel and reports the verdict. Depends on rrt_pkg, both
// channel interfaces, the block and tb_rrt_checker.
module tb_reserved_range_table_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  N_RANDOM = 620;
    localparam longint CYCLE_LIMIT = 2000000;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    int     errors, pending;
    longint cycles = 0;
    bit     calm = 1'b0;

    rrt_in_if  req_if ();
    rrt_out_if #(.CW(7)) rsp_if ();

    reserved_range_table_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    tb_rrt_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (req_if.valid),
        .i_req_ready   (req_if.ready),
        .i_cmd         (req_if.cmd),
        .i_range_start (req_if.range_start),
        .i_range_end   (req_if.range_end),
        .i_temporary   (req_if.temporary),
        .i_rsp_valid   (rsp_if.valid),
        .i_rsp_ready   (rsp_if.ready),
        .i_status      (rsp_if.status),
        .i_gap_start   (rsp_if.gap_start),
        .i_gap_end     (rsp_if.gap_end),
        .i_entry_count (rsp_if.entry_count),
        .o_errors      (errors),
        .o_pending     (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        req_if.valid = 1'b0;
        req_if.cmd = rrt_pkg::CMD_INSERT;
        req_if.range_start = '0;
        req_if.range_end = '0;
        req_if.temporary = 1'b0;
        rsp_if.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("reserved_range_table_unit: mismatch");
            $finish;
        end
    end

    // Result side stalls about 12% of the time, except in the calm stretch.
    always @(posedge i_clk)
        rsp_if.ready <= calm || ($urandom_range(99) >= 12);

    // Holds one beat on the request channel until it is taken. Valid stays
    // high after the beat so that a following beat can go out back to back.
    task automatic send_beat(logic [1:0] c, logic [63:0] s, logic [63:0] e, logic t);
        while (!calm && $urandom_range(99) < 12) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.cmd         <= c;
        req_if.range_start <= s;
        req_if.range_end   <= e;
        req_if.temporary   <= t;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    // Addresses mostly in a small area so that ranges collide; a few anywhere or near the top.
    function automatic logic [63:0] pick_addr();
        case ($urandom_range(9))
            0: return {$urandom, $urandom};
            1: return 64'hFFFF_FFFF_FFFF_F000 + 64'($urandom_range(4095));
            default: return 64'($urandom_range(32'h7FFFF));
        endcase
    endfunction

    initial begin
        logic [63:0] s, e;
        logic [1:0]  c;
        int          r;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_beat(rrt_pkg::CMD_REMOVE, 64'h1000, 64'h2000, 1'b0);        // empty table
        send_beat(rrt_pkg::CMD_FIND, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_beat(rrt_pkg::CMD_INSERT, 64'h5000, 64'h5000, 1'b0);        // empty range
        send_beat(rrt_pkg::CMD_INSERT, 64'h1000, 64'h3000, 1'b1);
        send_beat(rrt_pkg::CMD_INSERT, 64'h1800, 64'h2000, 1'b0);        // contained
        send_beat(rrt_pkg::CMD_INSERT, 64'h4000, 64'h6000, 1'b1);
        send_beat(rrt_pkg::CMD_INSERT, 64'h4800, 64'h5000, 1'b1);   // contained, both temp
        send_beat(rrt_pkg::CMD_INSERT, 64'h2800, 64'h4800, 1'b0);        // partial overlap
        send_beat(rrt_pkg::CMD_INSERT, 64'hFFFF_FFFF_FFFF_FF00, 64'hFFFF_FFFF_FFFF_FFFF,
                  1'b1);
        send_beat(rrt_pkg::CMD_FIND, 64'h1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_beat(rrt_pkg::CMD_FIND, 64'h7000, 64'h6000, 1'b0);           // reversed window
        send_beat(rrt_pkg::CMD_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                  1'b0);
        send_beat(rrt_pkg::CMD_FIND, 64'h3000, 64'h3FFF, 1'b0);
        send_beat(rrt_pkg::CMD_FIND, 64'hFFFF_FFFF_FFFF_0000, 64'hFFFF_FFFF_FFFF_FFFF,
                  1'b0);
        send_beat(rrt_pkg::CMD_REMOVE, 64'h1000, 64'h3000, 1'b0);
        send_beat(rrt_pkg::CMD_REMOVE, 64'h2000, 64'h1000, 1'b0);         // reversed range
        send_beat(rrt_pkg::CMD_PURGE, 64'h0, 64'h0, 1'b0);
        // Fill the table to its depth, then go two past it.
        for (int k = 0; k < 66; k++)
            send_beat(rrt_pkg::CMD_INSERT, 64'h100000 + 64'(k) * 64'h2000,
                      64'h101000 + 64'(k) * 64'h2000, k[0]);
        send_beat(rrt_pkg::CMD_INSERT, 64'h100000, 64'h100800, 1'b0);  // full, though contained
        send_beat(rrt_pkg::CMD_FIND, 64'h0, 64'h200000, 1'b0);
        send_beat(rrt_pkg::CMD_PURGE, 64'h0, 64'h0, 1'b0);

        for (int k = 0; k < N_RANDOM; k++) begin
            calm = (k >= 300 && k < 400);
            r = $urandom_range(99);
            c = (r < 50) ? rrt_pkg::CMD_INSERT : (r < 75) ? rrt_pkg::CMD_REMOVE :
                (r < 96) ? rrt_pkg::CMD_FIND : rrt_pkg::CMD_PURGE;
            s = pick_addr();
            e = (($urandom_range(9)) == 0) ? pick_addr() : s + 64'($urandom_range(32'h6000));
            send_beat(c, s, e, 1'($urandom));
        end
        calm = 1'b0;
        req_if.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("reserved_range_table_unit: match");
        end else begin
            $display("reserved_range_table_unit: mismatch");
        end
        $finish;
    end
endmodule
